// ----- rtl/vlp_pkg.sv -----
`default_nettype none

package vlp_pkg;

    localparam int TABLE_ENTRIES_DEF = 720;
    localparam int SPEAKERS_DEF      = 16;

    localparam logic [15:0] RAMP_RESET = 16'd1024;

    // Rounding offset and shift that turn azimuth times table size into an index.
    localparam int AZ_ROUND = 32768;
    localparam int AZ_SHIFT = 16;

    localparam int RAMP_SHIFT = 16;
    localparam int GAIN_SHIFT = 30;
    localparam int Q30_SHIFT  = 15;

    localparam int OBUF_DEPTH = 8;

    localparam int PROD_W = 59;

    typedef logic signed [PROD_W-1:0] wide_t;

    typedef enum logic [1:0] {
        FUNC_TABLE  = 2'd0,
        FUNC_DIR    = 2'd1,
        FUNC_SAMPLE = 2'd2
    } func_t;

    typedef struct packed {
        logic [15:0] gain_second;
        logic [15:0] gain_first;
        logic [3:0]  second;
        logic [3:0]  first;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic               valid;
        logic               step;
        logic [3:0]         ch;
        logic [30:0]        target;
        logic signed [23:0] sample;
        logic               last;
    } op_t;

    typedef struct packed {
        logic [3:0]         channel;
        logic signed [23:0] contribution;
        logic               last;
    } res_t;

    function automatic logic [3:0] spk_mod(input logic [3:0] v, input int unsigned n);
        int unsigned t;
        t = 32'(v);
        for (int i = 0; i < 8; i++) begin
            if (t >= n) begin
                t = t - n;
            end
        end
        return 4'(t);
    endfunction

    function automatic logic signed [31:0] sat32(input wide_t v);
        if (v[PROD_W-1:31] == '0 || v[PROD_W-1:31] == '1) begin
            return v[31:0];
        end
        return v[PROD_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic signed [23:0] sat24(input wide_t v);
        if (v[PROD_W-1:23] == '0 || v[PROD_W-1:23] == '1) begin
            return v[23:0];
        end
        return v[PROD_W-1] ? 24'h80_0000 : 24'h7F_FFFF;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/vlp_ram.sv -----
`default_nettype none

module vlp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/vlp_seq.sv -----
`default_nettype none

module vlp_seq #(
    parameter int TABLE_ENTRIES = vlp_pkg::TABLE_ENTRIES_DEF,
    parameter int SPEAKERS      = vlp_pkg::SPEAKERS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_func,
    input  wire logic [9:0]         s_table_index,
    input  wire logic [3:0]         s_entry_first_speaker,
    input  wire logic [3:0]         s_entry_second_speaker,
    input  wire logic [15:0]        s_entry_first_gain,
    input  wire logic [15:0]        s_entry_second_gain,
    input  wire logic [15:0]        s_azimuth_code,
    input  wire logic signed [23:0] s_sample_in,
    input  wire logic               res_pop,
    output vlp_pkg::op_t            op
);

    localparam int TAW    = $clog2(TABLE_ENTRIES);
    localparam int IDX_W  = $clog2(TABLE_ENTRIES + 1);
    localparam int AZP_W  = 16 + IDX_W;
    localparam int CRW    = $clog2(vlp_pkg::OBUF_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIR_RD,
        S_DIR_ENT,
        S_ISSUE,
        S_DRAIN0,
        S_DRAIN1
    } state_t;

    state_t state_reg, state_next, acc_state;

    logic [CRW-1:0]     credit_reg, credit_next;
    logic [7:0]         cur_reg, prev_reg;
    logic [3:0]         list_ch_reg [4];
    logic               list_v2_reg, list_v3_reg;
    logic [30:0]        tgt0_reg, tgt1_reg;
    logic               step_reg;
    logic signed [23:0] smp_reg;
    logic [1:0]         ptr_reg;
    logic [AZP_W-1:0]   azp_reg;

    logic               more, issue, issue_smp, accept;
    logic [1:0]         ptr_adv;
    vlp_pkg::func_t     func;

    logic                      tbl_we;
    logic [TAW-1:0]            tbl_waddr, tbl_raddr;
    vlp_pkg::entry_t           tbl_wentry, ent;
    logic [vlp_pkg::ENTRY_W-1:0] tbl_rdata;
    logic [AZP_W:0]            az_sum;
    logic [IDX_W:0]            idx_raw;

    assign func = vlp_pkg::func_t'(s_func);

    assign more = (ptr_reg == 2'd0) || (ptr_reg == 2'd1 && (list_v2_reg || list_v3_reg))
                  || (ptr_reg == 2'd2 && list_v3_reg);
    assign ptr_adv   = (ptr_reg == 2'd1 && !list_v2_reg) ? 2'd3 : ptr_reg + 2'd1;
    assign issue     = (state_reg == S_ISSUE) && (step_reg || credit_reg != '0);
    assign issue_smp = issue && !step_reg;
    assign s_ready   = (state_reg == S_IDLE) || (issue_smp && !more);
    assign accept    = s_valid && s_ready;

    assign credit_next = credit_reg - CRW'(issue_smp) + CRW'(res_pop);

    // Table writes land at acceptance; indexes past the table are dropped.
    assign tbl_we    = accept && func == vlp_pkg::FUNC_TABLE
                       && 32'(s_table_index) < 32'(TABLE_ENTRIES);
    assign tbl_waddr = TAW'(s_table_index);
    always_comb begin
        tbl_wentry.first       = vlp_pkg::spk_mod(s_entry_first_speaker, SPEAKERS);
        tbl_wentry.second      = vlp_pkg::spk_mod(s_entry_second_speaker, SPEAKERS);
        tbl_wentry.gain_first  = s_entry_first_gain;
        tbl_wentry.gain_second = s_entry_second_gain;
    end

    assign az_sum    = {1'b0, azp_reg} + (AZP_W + 1)'(vlp_pkg::AZ_ROUND);
    assign idx_raw   = az_sum[AZP_W:vlp_pkg::AZ_SHIFT];
    assign tbl_raddr = (32'(idx_raw) >= 32'(TABLE_ENTRIES)) ? '0 : TAW'(idx_raw);
    assign ent       = vlp_pkg::entry_t'(tbl_rdata);

    vlp_ram #(
        .WIDTH(vlp_pkg::ENTRY_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .aclk (aclk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(tbl_wentry),
        .raddr(tbl_raddr),
        .rdata(tbl_rdata)
    );

    always_comb begin
        unique case (func)
            vlp_pkg::FUNC_DIR:    acc_state = S_DIR_RD;
            vlp_pkg::FUNC_SAMPLE: acc_state = S_ISSUE;
            default:              acc_state = S_IDLE;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    state_next = acc_state;
                end
            end
            S_DIR_RD:  state_next = S_DIR_ENT;
            S_DIR_ENT: state_next = S_ISSUE;
            S_ISSUE: begin
                if (issue && !more) begin
                    if (step_reg) begin
                        state_next = S_DRAIN0;
                    end else if (accept) begin
                        state_next = acc_state;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_DRAIN0: state_next = S_DRAIN1;
            S_DRAIN1: state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            credit_reg <= CRW'(vlp_pkg::OBUF_DEPTH);
            cur_reg    <= '0;
            prev_reg   <= '0;
        end else begin
            state_reg  <= state_next;
            credit_reg <= credit_next;
            if (state_reg == S_DIR_ENT) begin
                prev_reg <= cur_reg;
                cur_reg  <= {ent.second, ent.first};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            azp_reg        <= AZP_W'(s_azimuth_code) * AZP_W'(TABLE_ENTRIES);
            smp_reg        <= s_sample_in;
            list_ch_reg[0] <= cur_reg[3:0];
            list_ch_reg[1] <= cur_reg[7:4];
            list_ch_reg[2] <= prev_reg[3:0];
            list_ch_reg[3] <= prev_reg[7:4];
            list_v2_reg    <= prev_reg[3:0] != cur_reg[3:0] && prev_reg[3:0] != cur_reg[7:4];
            list_v3_reg    <= prev_reg[7:4] != cur_reg[3:0] && prev_reg[7:4] != cur_reg[7:4];
            step_reg       <= 1'b0;
            ptr_reg        <= 2'd0;
        end else if (state_reg == S_DIR_ENT) begin
            list_ch_reg[0] <= ent.first;
            list_ch_reg[1] <= ent.second;
            list_ch_reg[2] <= cur_reg[3:0];
            list_ch_reg[3] <= cur_reg[7:4];
            list_v2_reg    <= cur_reg[3:0] != ent.first && cur_reg[3:0] != ent.second;
            list_v3_reg    <= cur_reg[7:4] != ent.first && cur_reg[7:4] != ent.second;
            tgt0_reg       <= {ent.gain_first, vlp_pkg::Q30_SHIFT'(0)};
            tgt1_reg       <= {ent.gain_second, vlp_pkg::Q30_SHIFT'(0)};
            step_reg       <= 1'b1;
            ptr_reg        <= 2'd0;
        end else if (issue && more) begin
            ptr_reg <= ptr_adv;
        end
    end

    always_comb begin
        op.valid  = issue;
        op.step   = step_reg;
        op.ch     = list_ch_reg[ptr_reg];
        op.target = (ptr_reg == 2'd0) ? tgt0_reg : (ptr_reg == 2'd1) ? tgt1_reg : '0;
        op.sample = smp_reg;
        op.last   = !more;
    end

endmodule

`default_nettype wire

// ----- rtl/vlp_wpath.sv -----
`default_nettype none

module vlp_wpath #(
    parameter int SPEAKERS = vlp_pkg::SPEAKERS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire vlp_pkg::op_t  op,
    input  wire logic [15:0]   ramp,
    output logic               push_valid,
    output vlp_pkg::res_t      push_data
);

    localparam int CW = $clog2(SPEAKERS);

    vlp_pkg::op_t       b_op_reg, c_op_reg, d_op_reg;
    logic               b_wv_reg, b_dv_reg;
    logic [SPEAKERS-1:0] wv_reg, dv_reg;
    logic               fw_valid_reg;
    logic [3:0]         fw_ch_reg;
    logic signed [31:0] fw_data_reg;
    logic signed [33:0] c_val_reg, c_val_next;
    vlp_pkg::wide_t     d_prod_reg, prod_next;

    logic [CW-1:0]      a_ch, b_ch, d_ch;
    logic [31:0]        w_rd, d_rd;
    logic signed [31:0] w_cur, d_cur, w_sum, delta_new;
    logic signed [32:0] w_sum33;
    logic signed [33:0] diff;
    logic signed [24:0] mul_b;
    logic               w_we, d_we;

    assign a_ch = CW'(op.ch);
    assign b_ch = CW'(b_op_reg.ch);
    assign d_ch = CW'(d_op_reg.ch);

    // The weight of the previous beat is still on its way into the memory.
    assign w_cur   = (fw_valid_reg && fw_ch_reg == b_op_reg.ch) ? fw_data_reg
                     : (b_wv_reg ? w_rd : '0);
    assign d_cur   = b_dv_reg ? d_rd : '0;
    assign w_sum33 = {w_cur[31], w_cur} + {d_cur[31], d_cur};
    assign w_sum   = vlp_pkg::sat32({{(vlp_pkg::PROD_W - 33){w_sum33[32]}}, w_sum33});
    assign diff    = {3'b000, b_op_reg.target} - {{2{w_cur[31]}}, w_cur};
    assign c_val_next = b_op_reg.step ? diff : {{2{w_sum[31]}}, w_sum};
    assign w_we    = b_op_reg.valid && !b_op_reg.step;

    assign mul_b     = c_op_reg.step ? {9'd0, ramp} : {c_op_reg.sample[23], c_op_reg.sample};
    assign prod_next = c_val_reg * mul_b;

    assign delta_new = vlp_pkg::sat32(d_prod_reg >>> vlp_pkg::RAMP_SHIFT);
    assign d_we      = d_op_reg.valid && d_op_reg.step;

    assign push_valid             = d_op_reg.valid && !d_op_reg.step;
    assign push_data.channel      = d_op_reg.ch;
    assign push_data.contribution = vlp_pkg::sat24(d_prod_reg >>> vlp_pkg::GAIN_SHIFT);
    assign push_data.last         = d_op_reg.last;

    vlp_ram #(
        .WIDTH(32),
        .DEPTH(SPEAKERS)
    ) u_weight (
        .aclk (aclk),
        .we   (w_we),
        .waddr(b_ch),
        .wdata(w_sum),
        .raddr(a_ch),
        .rdata(w_rd)
    );

    vlp_ram #(
        .WIDTH(32),
        .DEPTH(SPEAKERS)
    ) u_delta (
        .aclk (aclk),
        .we   (d_we),
        .waddr(d_ch),
        .wdata(delta_new),
        .raddr(a_ch),
        .rdata(d_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_op_reg.valid <= 1'b0;
            c_op_reg.valid <= 1'b0;
            d_op_reg.valid <= 1'b0;
            fw_valid_reg   <= 1'b0;
            wv_reg         <= '0;
            dv_reg         <= '0;
        end else begin
            b_op_reg     <= op;
            c_op_reg     <= b_op_reg;
            d_op_reg     <= c_op_reg;
            fw_valid_reg <= w_we;
            if (w_we) begin
                wv_reg[b_ch] <= 1'b1;
            end
            if (d_we) begin
                dv_reg[d_ch] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        b_wv_reg    <= wv_reg[a_ch];
        b_dv_reg    <= dv_reg[a_ch];
        fw_ch_reg   <= b_op_reg.ch;
        fw_data_reg <= w_sum;
        c_val_reg   <= c_val_next;
        d_prod_reg  <= prod_next;
    end

endmodule

`default_nettype wire

// ----- rtl/vlp_obuf.sv -----
`default_nettype none

module vlp_obuf (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push_valid,
    input  wire vlp_pkg::res_t push_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output vlp_pkg::res_t      res
);

    localparam int PW   = $clog2(vlp_pkg::OBUF_DEPTH);
    localparam int CNTW = $clog2(vlp_pkg::OBUF_DEPTH + 1);

    vlp_pkg::res_t  fifo_reg [vlp_pkg::OBUF_DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNTW-1:0] count_reg;
    logic           pop;

    assign m_valid = count_reg != '0;
    assign pop     = m_valid && m_ready;
    assign res     = fifo_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_valid) begin
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            count_reg <= count_reg + CNTW'(push_valid) - CNTW'(pop);
        end
    end

    always_ff @(posedge aclk) begin
        if (push_valid) begin
            fifo_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/vbap_lut_panner_with_gain_ramp.sv -----
`default_nettype none

// Table-driven 2-D amplitude panner with per-channel gain ramps. A table beat writes one
// pair entry and leaves the block ready for the next beat. A sample beat issues two to four
// channel updates, one per cycle through the weight memories, and the next beat is taken in
// the cycle the last update issues; contributions pass the b, c and d pipeline registers into
// an eight-beat output queue, and issue pauses while that queue has no free slot. Before the
// next beat is taken, a direction beat passes an index multiply, a table read, two to four
// ramp-step updates, and S_DRAIN0 and S_DRAIN1 for the step memory writes to settle.
module vbap_lut_panner_with_gain_ramp #(
    parameter int TABLE_ENTRIES = vlp_pkg::TABLE_ENTRIES_DEF,
    parameter int SPEAKERS      = vlp_pkg::SPEAKERS_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_func,
    input  wire logic [9:0]         s_table_index,
    input  wire logic [3:0]         s_entry_first_speaker,
    input  wire logic [3:0]         s_entry_second_speaker,
    input  wire logic [15:0]        s_entry_first_gain,
    input  wire logic [15:0]        s_entry_second_gain,
    input  wire logic [15:0]        s_azimuth_code,
    input  wire logic signed [23:0] s_sample_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [3:0]              m_channel,
    output logic signed [23:0]      m_contribution,
    output logic                    m_last
);

    logic [15:0]   ramp_reg;
    vlp_pkg::op_t  op;
    logic          push_valid;
    vlp_pkg::res_t push_data, res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ramp_reg <= vlp_pkg::RAMP_RESET;
        end else if (cfg_we) begin
            ramp_reg <= cfg_wdata;
        end
    end

    vlp_seq #(
        .TABLE_ENTRIES(TABLE_ENTRIES),
        .SPEAKERS     (SPEAKERS)
    ) u_seq (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_func                (s_func),
        .s_table_index         (s_table_index),
        .s_entry_first_speaker (s_entry_first_speaker),
        .s_entry_second_speaker(s_entry_second_speaker),
        .s_entry_first_gain    (s_entry_first_gain),
        .s_entry_second_gain   (s_entry_second_gain),
        .s_azimuth_code        (s_azimuth_code),
        .s_sample_in           (s_sample_in),
        .res_pop               (m_valid && m_ready),
        .op                    (op)
    );

    vlp_wpath #(
        .SPEAKERS(SPEAKERS)
    ) u_wpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .op        (op),
        .ramp      (ramp_reg),
        .push_valid(push_valid),
        .push_data (push_data)
    );

    vlp_obuf u_obuf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_data (push_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .res       (res)
    );

    assign m_channel      = res.channel;
    assign m_contribution = res.contribution;
    assign m_last         = res.last;

endmodule

`default_nettype wire

// ----- test/tb_vbap_lut_panner_with_gain_ramp.sv -----
module tb_vbap_lut_panner_with_gain_ramp;

    localparam int CLK_PERIOD = 12;
    localparam int unsigned N_ENTRIES = vlp_pkg::TABLE_ENTRIES_DEF;
    localparam int N_SPEAKERS = vlp_pkg::SPEAKERS_DEF;
    localparam logic [1:0] FUNC_NONE = 2'd3;
    localparam int SETTLE_CYCLES = 24;
    localparam int MAX_REPORTS = 10;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam longint W_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam longint W_MIN = -W_MAX - 1;
    localparam longint C_MAX = 8388607;
    localparam longint C_MIN = -8388608;

    typedef struct {
        logic [1:0]         func;
        logic [9:0]         tbl_index;
        logic [3:0]         spk_a;
        logic [3:0]         spk_b;
        logic [15:0]        gain_a;
        logic [15:0]        gain_b;
        logic [15:0]        azimuth;
        logic signed [23:0] sample;
    } pan_beat_t;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_we = 1'b0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    wire                s_ready;
    logic [1:0]         s_func = '0;
    logic [9:0]         s_table_index = '0;
    logic [3:0]         s_entry_first_speaker = '0;
    logic [3:0]         s_entry_second_speaker = '0;
    logic [15:0]        s_entry_first_gain = '0;
    logic [15:0]        s_entry_second_gain = '0;
    logic [15:0]        s_azimuth_code = '0;
    logic signed [23:0] s_sample_in = '0;
    wire                m_valid;
    logic               m_ready = 1'b0;
    wire [3:0]          m_channel;
    wire signed [23:0]  m_contribution;
    wire                m_last;

    vbap_lut_panner_with_gain_ramp dut (
        .aclk                   (aclk),
        .aresetn                (aresetn),
        .cfg_we                 (cfg_we),
        .cfg_wdata              (cfg_wdata),
        .s_valid                (s_valid),
        .s_ready                (s_ready),
        .s_func                 (s_func),
        .s_table_index          (s_table_index),
        .s_entry_first_speaker  (s_entry_first_speaker),
        .s_entry_second_speaker (s_entry_second_speaker),
        .s_entry_first_gain     (s_entry_first_gain),
        .s_entry_second_gain    (s_entry_second_gain),
        .s_azimuth_code         (s_azimuth_code),
        .s_sample_in            (s_sample_in),
        .m_valid                (m_valid),
        .m_ready                (m_ready),
        .m_channel              (m_channel),
        .m_contribution         (m_contribution),
        .m_last                 (m_last)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // Panner state as the block should hold it.
    logic [3:0]  tbl_spk_a  [N_ENTRIES];
    logic [3:0]  tbl_spk_b  [N_ENTRIES];
    logic [15:0] tbl_gain_a [N_ENTRIES];
    logic [15:0] tbl_gain_b [N_ENTRIES];
    int          weight [N_SPEAKERS];
    int          delta  [N_SPEAKERS];
    bit [3:0]    cur_a, cur_b, prev_a, prev_b;
    logic [15:0] ramp_cfg = vlp_pkg::RAMP_RESET;

    vlp_pkg::res_t expected_contribs [$];
    pan_beat_t     pending_beats [$];
    bit            gen_written [N_ENTRIES];
    int            queued_count = 0;
    int            accepted_count = 0;
    int            error_count = 0;
    int            gap_left = 0;
    int            stall_left = 0;
    int            send_calm = 0;
    int            recv_calm = 0;
    pan_beat_t     next_beat;
    pan_beat_t     seen_beat;
    vlp_pkg::res_t want;

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic int az_to_index(logic [15:0] code);
        int unsigned t;
        t = (32'(code) * N_ENTRIES + vlp_pkg::AZ_ROUND) >> vlp_pkg::AZ_SHIFT;
        return (t >= N_ENTRIES) ? 0 : int'(t);
    endfunction

    function automatic void step_toward(int ch, longint target);
        longint diff;
        diff = target - longint'(weight[ch]);
        delta[ch] = int'(clamp((diff * longint'(ramp_cfg)) >>> vlp_pkg::RAMP_SHIFT,
                               W_MIN, W_MAX));
    endfunction

    function automatic void emit_contrib(int ch, longint smp, bit is_last);
        vlp_pkg::res_t r;
        weight[ch] = int'(clamp(longint'(weight[ch]) + longint'(delta[ch]), W_MIN, W_MAX));
        r.channel = 4'(ch);
        r.contribution = 24'(clamp((longint'(weight[ch]) * smp) >>> vlp_pkg::GAIN_SHIFT,
                                   C_MIN, C_MAX));
        r.last = is_last;
        expected_contribs.insert(expected_contribs.size(), r);
    endfunction

    function automatic void panner_update(pan_beat_t b);
        int idx;
        int n_a;
        int n_b;
        int n;
        int chans [4];
        case (b.func)
            vlp_pkg::FUNC_TABLE: begin
                if (b.tbl_index < N_ENTRIES) begin
                    tbl_spk_a[b.tbl_index] = b.spk_a;
                    tbl_spk_b[b.tbl_index] = b.spk_b;
                    tbl_gain_a[b.tbl_index] = b.gain_a;
                    tbl_gain_b[b.tbl_index] = b.gain_b;
                end
            end
            vlp_pkg::FUNC_DIR: begin
                idx = az_to_index(b.azimuth);
                n_a = tbl_spk_a[idx];
                n_b = tbl_spk_b[idx];
                step_toward(n_a, longint'(tbl_gain_a[idx]) <<< vlp_pkg::Q30_SHIFT);
                step_toward(n_b, longint'(tbl_gain_b[idx]) <<< vlp_pkg::Q30_SHIFT);
                if (cur_a != n_a && cur_a != n_b) begin
                    step_toward(cur_a, 0);
                end
                if (cur_b != n_a && cur_b != n_b) begin
                    step_toward(cur_b, 0);
                end
                prev_a = cur_a;
                prev_b = cur_b;
                cur_a = 4'(n_a);
                cur_b = 4'(n_b);
            end
            vlp_pkg::FUNC_SAMPLE: begin
                chans[0] = cur_a;
                chans[1] = cur_b;
                n = 2;
                if (prev_a != cur_a && prev_a != cur_b) begin
                    chans[n] = prev_a;
                    n = n + 1;
                end
                if (prev_b != cur_a && prev_b != cur_b) begin
                    chans[n] = prev_b;
                    n = n + 1;
                end
                for (int k = 0; k < n; k++) begin
                    emit_contrib(chans[k], longint'(b.sample), k == n - 1);
                end
            end
            default: begin
            end
        endcase
    endfunction

    task automatic log_error(string msg);
        error_count++;
        if (error_count <= MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
    endtask

    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0) begin
            calm = calm - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(10, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            gap_left <= 0;
        end else if (!s_valid || s_ready) begin
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                s_valid <= 1'b0;
            end else if (pending_beats.size() != 0) begin
                next_beat = pending_beats.pop_front();
                s_func <= next_beat.func;
                s_table_index <= next_beat.tbl_index;
                s_entry_first_speaker <= next_beat.spk_a;
                s_entry_second_speaker <= next_beat.spk_b;
                s_entry_first_gain <= next_beat.gain_a;
                s_entry_second_gain <= next_beat.gain_b;
                s_azimuth_code <= next_beat.azimuth;
                s_sample_in <= next_beat.sample;
                s_valid <= 1'b1;
                gap_left <= pick_gap(send_calm);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_ready <= 1'b1;
            stall_left <= pick_gap(recv_calm);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                seen_beat.func = s_func;
                seen_beat.tbl_index = s_table_index;
                seen_beat.spk_a = s_entry_first_speaker;
                seen_beat.spk_b = s_entry_second_speaker;
                seen_beat.gain_a = s_entry_first_gain;
                seen_beat.gain_b = s_entry_second_gain;
                seen_beat.azimuth = s_azimuth_code;
                seen_beat.sample = s_sample_in;
                panner_update(seen_beat);
                accepted_count++;
            end
            if (m_valid && m_ready) begin
                if (expected_contribs.size() == 0) begin
                    log_error($sformatf("unexpected beat: channel %0d contribution %0d last %0d",
                                        m_channel, m_contribution, m_last));
                end else begin
                    want = expected_contribs.pop_front();
                    if (m_channel !== want.channel) begin
                        log_error($sformatf("channel: expected %0d, got %0d",
                                            want.channel, m_channel));
                    end
                    if (m_contribution !== want.contribution) begin
                        log_error($sformatf("contribution on channel %0d: expected %0d, got %0d",
                                            want.channel, want.contribution, m_contribution));
                    end
                    if (m_last !== want.last) begin
                        log_error($sformatf("last on channel %0d: expected %0d, got %0d",
                                            want.channel, want.last, m_last));
                    end
                end
            end
        end
    end

    function automatic pan_beat_t random_beat(logic [1:0] func);
        pan_beat_t b;
        b.func = func;
        b.tbl_index = 10'($urandom);
        b.spk_a = 4'($urandom);
        b.spk_b = 4'($urandom);
        b.gain_a = 16'($urandom_range(0, 32768));
        b.gain_b = 16'($urandom_range(0, 32768));
        b.azimuth = 16'($urandom);
        b.sample = 24'($urandom);
        return b;
    endfunction

    function automatic int pick_gain();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 32768;
            default: return $urandom_range(0, 32768);
        endcase
    endfunction

    function automatic logic signed [23:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 24'sh80_0000;
            1: return 24'sh7F_FFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 9))
            0: return 16'($urandom_range(65440, 65535));
            1: return 16'($urandom_range(0, 50));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic push_beat(pan_beat_t b);
        pending_beats.insert(pending_beats.size(), b);
        queued_count++;
    endtask

    task automatic push_table(int idx, int a, int b, int ga, int gb);
        pan_beat_t t;
        t = random_beat(vlp_pkg::FUNC_TABLE);
        t.tbl_index = 10'(idx);
        t.spk_a = 4'(a);
        t.spk_b = 4'(b);
        t.gain_a = 16'(ga);
        t.gain_b = 16'(gb);
        if (t.tbl_index < N_ENTRIES) begin
            gen_written[t.tbl_index] = 1'b1;
        end
        push_beat(t);
    endtask

    // A direction beat may only look up an entry that has been written.
    task automatic push_direction(logic [15:0] code);
        pan_beat_t t;
        int idx;
        idx = az_to_index(code);
        if (!gen_written[idx]) begin
            push_table(idx, $urandom, $urandom, pick_gain(), pick_gain());
        end
        t = random_beat(vlp_pkg::FUNC_DIR);
        t.azimuth = code;
        push_beat(t);
    endtask

    task automatic push_sample(logic signed [23:0] smp);
        pan_beat_t t;
        t = random_beat(vlp_pkg::FUNC_SAMPLE);
        t.sample = smp;
        push_beat(t);
    endtask

    task automatic run_directed();
        push_sample(24'sh80_0000);
        push_beat(random_beat(FUNC_NONE));
        push_table(0, 3, 3, 32768, 16384);
        push_table(719, 15, 0, 32768, 0);
        push_table(1023, 5, 6, 32768, 32768);
        push_table(720, 7, 8, 1000, 2000);
        push_direction(16'd65535);
        push_sample(24'sh7F_FFFF);
        push_sample(24'sh80_0000);
        push_sample(24'sd0);
        push_direction(16'd65420);
        push_sample(24'sd1);
        push_sample(-24'sd1);
        push_sample(24'sh7F_FFFF);
        push_table(5, 15, 15, 0, 32768);
        push_direction(16'd455);
        push_sample(24'sh80_0000);
        push_sample(24'sh40_0000);
        push_direction(16'd0);
        push_sample(24'sh7F_FFFF);
        push_sample(24'sh2A_AAAA);
    endtask

    task automatic run_random(int count);
        int start;
        int r;
        int n_smp;
        start = queued_count;
        while (queued_count - start < count) begin
            r = $urandom_range(0, 99);
            if (r < 6) begin
                push_table($urandom_range(0, N_ENTRIES - 1), $urandom, $urandom,
                           pick_gain(), pick_gain());
            end else if (r < 8) begin
                push_table($urandom_range(N_ENTRIES, 1023), $urandom, $urandom,
                           pick_gain(), pick_gain());
            end else if (r < 10) begin
                push_beat(random_beat(FUNC_NONE));
            end else begin
                push_direction(pick_code());
                r = $urandom_range(0, 9);
                if (r < 7) begin
                    n_smp = $urandom_range(1, 10);
                end else if (r < 9) begin
                    n_smp = $urandom_range(11, 40);
                end else begin
                    n_smp = $urandom_range(60, 140);
                end
                if (n_smp > count - (queued_count - start)) begin
                    n_smp = count - (queued_count - start);
                end
                if (n_smp < 0) begin
                    n_smp = 0;
                end
                repeat (n_smp) push_sample(pick_sample());
            end
        end
    endtask

    task automatic wait_idle();
        while (accepted_count != queued_count || expected_contribs.size() != 0) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_ramp(logic [15:0] v);
        wait_idle();
        cfg_we <= 1'b1;
        cfg_wdata <= v;
        ramp_cfg = v;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [15:0] ramp_plan [6];
        ramp_plan[0] = 16'hFFFF;
        ramp_plan[1] = 16'h0000;
        ramp_plan[2] = 16'h0001;
        ramp_plan[3] = 16'h8000;
        ramp_plan[4] = 16'($urandom);
        ramp_plan[5] = vlp_pkg::RAMP_RESET;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        run_directed();
        run_random(45);
        for (int i = 0; i < 6; i++) begin
            write_ramp(ramp_plan[i]);
            run_random(65);
        end
        wait_idle();
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule
